// File: rtl/bts_pkg.sv
// Shared constants and types for the binary trie set core.
// Depends on nothing; imported by bts_node_ram users and binary_trie_set_core.
package bts_pkg;

    // Key and node pool geometry
    localparam int KEY_BITS   = 32;
    localparam int NODE_COUNT = 4096;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int FREE_W     = $clog2(NODE_COUNT + 1);
    localparam int REM_W      = $clog2(KEY_BITS + 1);
    localparam int KIDX_W     = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

    // Operation codes carried on s_tuser
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_ERASE  = 2'd1;
    localparam logic [1:0] ACT_FIND   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // One trie node as held in the node RAM
    typedef struct packed {
        logic              leaf;
        logic [NODE_W-1:0] one_child;
        logic [NODE_W-1:0] zero_child;
    } node_entry_t;

    localparam int ENTRY_W = $bits(node_entry_t);

endpackage

// File: rtl/bts_node_ram.sv
// Single-port-write, single-port-read synchronous RAM for trie nodes.
// Read data is registered. No package dependency.
module bts_node_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 25
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/binary_trie_set_core.sv
// Binary trie set core: insert / erase / find of 32-bit keys in a node RAM.
// Depends on bts_pkg and bts_node_ram.
//
// Each transaction carries a key on s_tdata and an operation on s_tuser
// (0 insert, 1 erase, 2 find, 3 ignored). The key is walked from its top bit
// down, one node RAM read per bit, since every read address is the child
// pointer returned by the previous read. A walk that meets a missing path on
// erase or find ends early, and an ignored operation goes straight to the
// result register with no RAM read. Inserts allocate new nodes from a pool
// counter and write them one per cycle with no further reads. One item is
// in flight at a time; s_tready is high only between items. After reset the
// root node entry is cleared in ST_INIT; no transaction is taken before
// that. Nodes are never freed, so once the pool is spent inserts needing
// new nodes report pool_full.
module binary_trie_set_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bts_pkg::KEY_BITS-1:0]  s_tdata,  // [31:0] key
    input  logic [1:0]                    s_tuser,  // [1:0] action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata   // [0] found, [1] pool_full, [7:2] zero
);

    import bts_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOK,
        ST_ALLOC,
        ST_DONE
    } state_t;

    state_t                state_reg,  state_next;
    logic [1:0]            action_reg, action_next;
    logic [KEY_BITS-1:0]   key_reg,    key_next;
    logic [NODE_W-1:0]     node_reg,   node_next;
    logic [REM_W-1:0]      rem_reg,    rem_next;
    logic [FREE_W-1:0]     free_reg,   free_next;
    logic                  found_reg,  found_next;
    logic                  full_reg,   full_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  m_found_reg,  m_found_next;
    logic                  m_full_reg,   m_full_next;

    // Node RAM port signals
    logic                  mem_we;
    logic [NODE_W-1:0]     mem_wr_addr;
    node_entry_t           mem_wr_entry;
    logic                  mem_rd_en;
    logic [NODE_W-1:0]     mem_rd_addr;
    logic [ENTRY_W-1:0]    mem_rd_data;

    node_entry_t           entry;
    node_entry_t           upd_entry;
    logic [KIDX_W-1:0]     bit_idx;
    logic                  key_bit;
    logic [NODE_W-1:0]     child;
    logic                  pool_ok;
    logic [NODE_W-1:0]     new_node;

    bts_node_ram #(
        .DEPTH (NODE_COUNT),
        .WIDTH (ENTRY_W)
    ) u_node_ram (
        .aclk    (aclk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_entry),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Decode of the node just read and of the current key bit
    always_comb begin
        entry    = node_entry_t'(mem_rd_data);
        bit_idx  = KIDX_W'(rem_reg - REM_W'(1));
        key_bit  = key_reg[bit_idx];
        child    = key_bit ? entry.one_child : entry.zero_child;
        pool_ok  = free_reg < FREE_W'(NODE_COUNT);
        new_node = free_reg[NODE_W-1:0];
        upd_entry = entry;
        if (key_bit) begin
            upd_entry.one_child = new_node;
        end else begin
            upd_entry.zero_child = new_node;
        end
    end

    // Walk sequencer
    always_comb begin
        state_next    = state_reg;
        action_next   = action_reg;
        key_next      = key_reg;
        node_next     = node_reg;
        rem_next      = rem_reg;
        free_next     = free_reg;
        found_next    = found_reg;
        full_next     = full_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_found_next  = m_found_reg;
        m_full_next   = m_full_reg;
        mem_we        = 1'b0;
        mem_wr_addr   = node_reg;
        mem_wr_entry  = '0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = child;

        unique case (state_reg)
            // Clear the root entry; every other entry is written on allocation
            ST_INIT: begin
                mem_we      = 1'b1;
                mem_wr_addr = '0;
                state_next  = ST_IDLE;
            end

            ST_IDLE: begin
                if (s_tvalid) begin
                    action_next = s_tuser;
                    key_next    = s_tdata;
                    node_next   = '0;
                    rem_next    = REM_W'(KEY_BITS);
                    found_next  = 1'b0;
                    full_next   = 1'b0;
                    if (s_tuser == ACT_UNUSED) begin
                        state_next = ST_DONE;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        state_next  = ST_LOOK;
                    end
                end
            end

            // Entry of node_reg is on the RAM output
            ST_LOOK: begin
                priority if (rem_reg == '0) begin
                    // Final node: apply the leaf operation
                    unique case (action_reg)
                        ACT_INSERT: begin
                            mem_we        = 1'b1;
                            mem_wr_entry  = entry;
                            mem_wr_entry.leaf = 1'b1;
                            found_next    = 1'b1;
                        end
                        ACT_ERASE: begin
                            mem_we        = 1'b1;
                            mem_wr_entry  = entry;
                            mem_wr_entry.leaf = 1'b0;
                            found_next    = entry.leaf;
                        end
                        default: begin
                            found_next    = entry.leaf;
                        end
                    endcase
                    state_next = ST_DONE;
                end else if (child != '0) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = child;
                    node_next   = child;
                    rem_next    = rem_reg - REM_W'(1);
                end else if (action_reg != ACT_INSERT) begin
                    state_next = ST_DONE;
                end else if (!pool_ok) begin
                    full_next  = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    // Link a fresh node into the parent
                    mem_we       = 1'b1;
                    mem_wr_entry = upd_entry;
                    node_next    = new_node;
                    free_next    = free_reg + FREE_W'(1);
                    rem_next     = rem_reg - REM_W'(1);
                    state_next   = ST_ALLOC;
                end
            end

            // node_reg is freshly allocated; rest of the path is built blind
            ST_ALLOC: begin
                mem_we = 1'b1;
                priority if (rem_reg == '0) begin
                    mem_wr_entry.leaf = 1'b1;
                    found_next        = 1'b1;
                    state_next        = ST_DONE;
                end else if (pool_ok) begin
                    if (key_bit) begin
                        mem_wr_entry.one_child = new_node;
                    end else begin
                        mem_wr_entry.zero_child = new_node;
                    end
                    node_next = new_node;
                    free_next = free_reg + FREE_W'(1);
                    rem_next  = rem_reg - REM_W'(1);
                end else begin
                    full_next  = 1'b1;
                    state_next = ST_DONE;
                end
            end

            // Hand the result to the output register once it is free
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = found_reg;
                    m_full_next   = full_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            free_reg     <= FREE_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            free_reg     <= free_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        action_reg  <= action_next;
        key_reg     <= key_next;
        node_reg    <= node_next;
        rem_reg     <= rem_next;
        found_reg   <= found_next;
        full_reg    <= full_next;
        m_found_reg <= m_found_next;
        m_full_reg  <= m_full_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_full_reg, m_found_reg};

`ifndef SYNTH
    // Pool counter never runs past the end of the node RAM
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= FREE_W'(NODE_COUNT) && free_reg != '0)
        else $error("next-free counter out of range");

    // The RAM is never written between items
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !mem_we)
        else $error("node RAM written outside a walk");

    // A result never reports both a hit and an exhausted pool
    a_result_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_found_reg && m_full_reg))
        else $error("found and pool_full both set");

    // Allocation writes go to the node just handed out
    a_alloc_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ALLOC && rem_reg != '0 && pool_ok) |=>
            (node_reg == NODE_W'(free_reg - FREE_W'(1))))
        else $error("allocated node does not match pool counter");

    // Pool counter only moves while building a path
    a_free_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |=> $stable(free_reg))
        else $error("pool counter changed between items");
`endif

endmodule

// File: tb/bts_reply_checker.sv
// Watching checker for binary_trie_set_core: mirrors the trie on every accepted
// request transaction and compares each result transaction against it.
// Depends on bts_pkg for key width, pool geometry and operation codes.
module bts_reply_checker
    import bts_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [KEY_BITS-1:0] s_tdata,   // [31:0] key
    input  logic [1:0]          s_tuser,   // [1:0] action
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [7:0]          m_tdata,   // [0] found, [1] pool_full, [7:2] zero
    output int                  n_errors,
    output int                  n_pending
);

    // One predicted reply, with the request kept for messages
    typedef struct packed {
        logic [1:0]          act;
        logic [KEY_BITS-1:0] key;
        logic                found;
        logic                pool_full;
    } trie_reply_t;

    // Mirror of the trie
    logic [NODE_W-1:0] zero_kid [NODE_COUNT];
    logic [NODE_W-1:0] one_kid  [NODE_COUNT];
    logic              marked   [NODE_COUNT];
    logic [FREE_W-1:0] pool_next;

    trie_reply_t replies_due[$];
    int          err_total = 0;

    // Walk the key top bit first, growing the path on insert, and update the mark
    task automatic trie_apply(input logic [1:0] act, input logic [KEY_BITS-1:0] key,
                              output trie_reply_t rep);
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] kid;
        logic              reached;
        int                lvl;
        rep           = '0;
        rep.act       = act;
        rep.key       = key;
        node          = '0;
        reached       = (act != ACT_UNUSED);
        for (lvl = KEY_BITS - 1; lvl >= 0 && reached; lvl--) begin
            kid = key[lvl] ? one_kid[node] : zero_kid[node];
            if (kid == '0) begin
                if (act != ACT_INSERT) begin
                    reached = 1'b0;
                end else if (pool_next >= NODE_COUNT) begin
                    // pool spent: nodes taken earlier in this walk stay
                    reached       = 1'b0;
                    rep.pool_full = 1'b1;
                end else begin
                    kid           = pool_next[NODE_W-1:0];
                    pool_next     = pool_next + 1'b1;
                    zero_kid[kid] = '0;
                    one_kid[kid]  = '0;
                    marked[kid]   = 1'b0;
                    if (key[lvl]) begin
                        one_kid[node] = kid;
                    end else begin
                        zero_kid[node] = kid;
                    end
                end
            end
            node = kid;
        end
        if (reached) begin
            case (act)
                ACT_INSERT: begin
                    marked[node] = 1'b1;
                    rep.found    = 1'b1;
                end
                ACT_ERASE: begin
                    rep.found    = marked[node];
                    marked[node] = 1'b0;
                end
                ACT_FIND: begin
                    rep.found = marked[node];
                end
                default: ;
            endcase
        end
    endtask

    // Track both channels; results are checked before a new request is mirrored
    always @(posedge aclk) begin
        trie_reply_t due;
        trie_reply_t fresh;
        int          n;
        if (!aresetn) begin
            for (n = 0; n < NODE_COUNT; n++) begin
                zero_kid[n] = '0;
                one_kid[n]  = '0;
                marked[n]   = 1'b0;
            end
            pool_next = FREE_W'(1);
            replies_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $error("result transaction with no request outstanding: m_tdata %h",
                           m_tdata);
                    err_total++;
                end else begin
                    due = replies_due.pop_front();
                    if (m_tdata[0] !== due.found) begin
                        $error("found: expected %0b, got %0b (action %0d, key %h)",
                               due.found, m_tdata[0], due.act, due.key);
                        err_total++;
                    end
                    if (m_tdata[1] !== due.pool_full) begin
                        $error("pool_full: expected %0b, got %0b (action %0d, key %h)",
                               due.pool_full, m_tdata[1], due.act, due.key);
                        err_total++;
                    end
                    if (m_tdata[7:2] !== 6'd0) begin
                        $error("padding: expected %h, got %h (action %0d, key %h)",
                               6'd0, m_tdata[7:2], due.act, due.key);
                        err_total++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                trie_apply(s_tuser, s_tdata, fresh);
                replies_due.push_back(fresh);
            end
        end
        n_pending <= replies_due.size();
        n_errors  <= err_total;
    end

endmodule

// File: tb/testbench.sv
// Top of the binary trie set bench: clock, reset, request stimulus and result
// pacing, with bts_reply_checker alongside the core. Depends on bts_pkg,
// binary_trie_set_core and bts_reply_checker.
module testbench;
    import bts_pkg::*;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [KEY_BITS-1:0] s_tdata  = '0;   // [31:0] key
    logic [1:0]          s_tuser  = ACT_FIND;   // [1:0] action
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;   // [0] found, [1] pool_full, [7:2] zero

    int n_errors;
    int n_pending;

    // Calm stretches switch idling off on one side
    bit src_calm = 1'b0;
    bit snk_calm = 1'b0;

    // Keys already used, and a few shared prefixes, to revisit existing paths
    logic [KEY_BITS-1:0] known_keys[$];
    logic [KEY_BITS-1:0] family_base[8];

    binary_trie_set_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bts_reply_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .n_errors  (n_errors),
        .n_pending (n_pending)
    );

    // Clock, period 12
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Mostly keys on or near existing paths, some fresh ones to drain the pool
    function automatic logic [KEY_BITS-1:0] pick_key();
        int                  sel;
        logic [KEY_BITS-1:0] k;
        sel = $urandom_range(0, 99);
        if (known_keys.size() == 0 || sel < 25) begin
            k = $urandom();
        end else if (sel < 60) begin
            k = known_keys[$urandom_range(0, known_keys.size() - 1)];
        end else if (sel < 80) begin
            k = known_keys[$urandom_range(0, known_keys.size() - 1)]
                ^ ($urandom() & 32'h0000_0fff);
        end else if (sel < 95) begin
            k = {family_base[$urandom_range(0, 7)][31:8], 8'($urandom())};
        end else begin
            case ($urandom_range(0, 3))
                0:       k = '0;
                1:       k = '1;
                2:       k = 32'h1 << $urandom_range(0, 31);
                default: k = ~(32'h1 << $urandom_range(0, 31));
            endcase
        end
        return k;
    endfunction

    // Drop s_tvalid for a random gap after a transaction
    task automatic source_gap();
        int g;
        g = pick_gap(src_calm);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Present one request and hold it until the core takes it
    task automatic drive_op(input logic [1:0] act, input logic [KEY_BITS-1:0] key);
        source_gap();
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Result side back-pressure
    initial begin : sink_pacing
        int g;
        forever begin
            g = pick_gap(snk_calm);
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Change idling mood: source and sink each turn calm with a one in four chance
    initial begin : mood
        forever begin
            repeat (400) @(posedge aclk);
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        int                  n_sent;
        int                  r;
        logic [1:0]          act;
        logic [KEY_BITS-1:0] key;
        for (int i = 0; i < 8; i++) begin
            family_base[i] = $urandom();
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty trie, extremes, shared prefixes, erase then re-find
        drive_op(ACT_FIND,   32'h0000_0000);   // missing path
        drive_op(ACT_ERASE,  32'h0000_0000);   // missing path
        drive_op(ACT_INSERT, 32'h0000_0000);
        drive_op(ACT_INSERT, 32'h0000_0000);   // already present
        drive_op(ACT_FIND,   32'h0000_0000);
        drive_op(ACT_INSERT, 32'hffff_ffff);
        drive_op(ACT_FIND,   32'hffff_ffff);
        drive_op(ACT_FIND,   32'hffff_fffe);   // path breaks at the last bit
        drive_op(ACT_INSERT, 32'hffff_fffe);
        drive_op(ACT_ERASE,  32'hffff_ffff);
        drive_op(ACT_ERASE,  32'hffff_ffff);   // path there, mark already clear
        drive_op(ACT_FIND,   32'hffff_ffff);
        drive_op(ACT_UNUSED, 32'hffff_ffff);
        drive_op(ACT_UNUSED, 32'h0000_0000);
        drive_op(ACT_INSERT, 32'h8000_0000);
        drive_op(ACT_FIND,   32'h7fff_ffff);
        drive_op(ACT_INSERT, 32'h7fff_ffff);
        drive_op(ACT_INSERT, 32'h5555_5555);
        drive_op(ACT_INSERT, 32'haaaa_aaaa);
        drive_op(ACT_FIND,   32'h5555_5555);
        drive_op(ACT_FIND,   32'hffff_fffe);
        drive_op(ACT_ERASE,  32'h0000_0000);
        drive_op(ACT_FIND,   32'h0000_0000);
        drive_op(ACT_INSERT, 32'h0000_0000);   // reuses the old path
        known_keys = '{32'h0, 32'hffff_ffff, 32'hffff_fffe, 32'h8000_0000,
                       32'h7fff_ffff, 32'h5555_5555, 32'haaaa_aaaa};

        // Random mix; the pool runs dry part way through
        n_sent = 0;
        while (n_sent < 1080) begin
            if (n_sent == 350 || n_sent == 800) begin
                // let the core drain completely before carrying on
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (n_pending != 0);
            end
            r   = $urandom_range(0, 99);
            key = pick_key();
            if (r < 45) begin
                act = ACT_INSERT;
            end else if (r < 65) begin
                act = ACT_ERASE;
            end else if (r < 95) begin
                act = ACT_FIND;
            end else begin
                act = ACT_UNUSED;
            end
            drive_op(act, key);
            if (act != ACT_UNUSED) begin
                n_sent++;
            end
            if (act == ACT_INSERT) begin
                known_keys.push_back(key);
                if (known_keys.size() > 96) begin
                    void'(known_keys.pop_front());
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for a late stray result
        do @(posedge aclk); while (n_pending != 0);
        repeat (80) @(posedge aclk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(12 * 1000000);
        $display("status: fail");
        $finish;
    end

endmodule
